// ===== rtl/mpts_pkg.sv =====
`timescale 1ns / 1ps
// mpts_pkg: shared constants for the multilevel priority task scheduler
// item kinds, configuration register indexes, reset values and fixed field widths; no dependencies

package mpts_pkg;

	localparam int PRIO_W    = 5;
	localparam int QUANTUM_W = 16;
	localparam int BOOST_W   = 4;

	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_ADD    = 3'd1;
	localparam logic [2:0] KIND_WAKE   = 3'd2;
	localparam logic [2:0] KIND_YIELD  = 3'd3;
	localparam logic [2:0] KIND_SLEEP  = 3'd4;
	localparam logic [2:0] KIND_REMOVE = 3'd5;

	localparam logic [0:0] REG_AI_BOOST = 1'b0;
	localparam logic [0:0] REG_IDLE_ID  = 1'b1;

	localparam logic [BOOST_W-1:0] BOOST_RESET   = 4'd2;
	localparam logic [7:0]         IDLE_ID_RESET = 8'd1;

endpackage

// ===== rtl/mpts_ram.sv =====
`timescale 1ns / 1ps
// mpts_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module mpts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/multilevel_priority_task_scheduler_core.sv =====
`timescale 1ns / 1ps
// multilevel_priority_task_scheduler_core: per-level fifo rings in one ram plus a sequencer
// depends on mpts_pkg and mpts_ram
// remove walks its ring entry by entry to find the task, then closes up the ring behind it
// one item at a time: busy is high from acceptance until the result strobe has gone
// results last one cycle under result_valid and the receiver cannot stall them
// reset: rings empty, nothing running, all counters zero, ai_boost 2, idle task 1

module multilevel_priority_task_scheduler_core #(
	parameter int LEVELS        = 10,
	parameter int QUEUE_DEPTH   = 16,
	parameter int TASK_ID_WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [0:0]               cfg_index,
	input  logic [7:0]               cfg_data,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               kind,
	input  logic [TASK_ID_WIDTH-1:0] task_id,
	input  logic [3:0]               base_priority,
	input  logic                     ai_flag,
	input  logic [15:0]              task_quantum,
	output logic                     result_valid,
	output logic [TASK_ID_WIDTH-1:0] running_task,
	output logic                     running_idle,
	output logic                     switched,
	output logic                     dropped,
	output logic [7:0]               ready_count,
	output logic [31:0]              switch_count,
	output logic [31:0]              boosted_switches,
	output logic [31:0]              idle_ticks,
	output logic [31:0]              tick_count
);

	localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int HW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = LEVELS * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int RCB   = $clog2(DEPTH + 1);
	localparam int RCW   = (RCB < 8) ? 8 : RCB;
	localparam int PW    = mpts_pkg::PRIO_W;
	localparam int QW    = mpts_pkg::QUANTUM_W;
	localparam int EW    = TASK_ID_WIDTH + PW + 1 + QW;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_ENQ   = 4'd2;
	localparam logic [3:0] S_DQ    = 4'd3;
	localparam logic [3:0] S_SW    = 4'd4;
	localparam logic [3:0] S_RM    = 4'd5;
	localparam logic [3:0] S_RMC   = 4'd6;
	localparam logic [3:0] S_SH    = 4'd7;
	localparam logic [3:0] S_SHW   = 4'd8;
	localparam logic [3:0] S_RMEND = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	typedef struct packed {
		logic [TASK_ID_WIDTH-1:0] id;
		logic [PW-1:0]            prio;
		logic                     flag;
		logic [QW-1:0]            quantum;
	} entry_t;

	function automatic logic [LW-1:0] eff_idx(input logic [PW-1:0] p, input logic f,
			input logic [mpts_pkg::BOOST_W-1:0] b);
		logic [5:0] s;
		logic [5:0] m;
		begin
			if (p == '0) s = 6'd1;
			else if ({1'b0, p} > 6'(LEVELS)) s = 6'(LEVELS);
			else s = {1'b0, p};
			if (f) begin
				s = s + {2'b0, b};
				if (s > 6'(LEVELS)) s = 6'(LEVELS);
			end
			m = s - 6'd1;
			return m[LW-1:0];
		end
	endfunction

	function automatic logic [HW-1:0] wrap(input logic [HW-1:0] h, input logic [CW-1:0] o);
		logic [HW:0] s;
		begin
			s = (HW+1)'(h) + (HW+1)'(o);
			if (s >= (HW+1)'(QUEUE_DEPTH)) s = s - (HW+1)'(QUEUE_DEPTH);
			return s[HW-1:0];
		end
	endfunction

	logic [3:0]                  state_q;
	logic [2:0]                  kind_q;
	entry_t                      t_q;
	entry_t                      enq_q;
	entry_t                      cur_e_q;
	logic [TASK_ID_WIDTH-1:0]    cur_task_q;
	logic                        cur_valid_q;
	logic                        cur_idle_q;
	logic [QW-1:0]               qused_q;
	logic [31:0]                 sw_total_q;
	logic [31:0]                 boost_total_q;
	logic [31:0]                 idle_total_q;
	logic [31:0]                 ticks_q;
	logic                        sw_q;
	logic                        drop_q;
	logic                        pend_q;
	logic                        old_q;
	logic                        got_q;
	logic                        found_q;
	logic [LW-1:0]               lvl_q;
	logic [CW-1:0]               i_q;
	logic [CW-1:0]               j_q;
	logic [HW-1:0]               head_q [LEVELS];
	logic [CW-1:0]               count_q [LEVELS];
	logic [RCW-1:0]              ready_q;
	logic [mpts_pkg::BOOST_W-1:0] boost_q;
	logic [TASK_ID_WIDTH-1:0]    idle_id_q;

	logic [LW-1:0] top_lv;
	logic          any_ready;
	logic          any_above_cur;
	logic [LW-1:0] cur_lv;
	logic [LW-1:0] t_lv;
	logic [LW-1:0] enq_lv;
	logic [LW-1:0] ptr_lv;
	logic [CW-1:0] ptr_off;
	logic [AW-1:0] ptr_addr;
	logic          mem_we;
	logic [EW-1:0] mem_rdata;
	entry_t        rd_e;
	entry_t        in_e;
	logic [31:0]   idle_ext;
	logic [PW-1:0] in_prio;

	assign cur_lv = eff_idx(cur_e_q.prio, cur_e_q.flag, boost_q);
	assign t_lv   = eff_idx(t_q.prio, t_q.flag, boost_q);
	assign enq_lv = eff_idx(enq_q.prio, enq_q.flag, boost_q);
	assign rd_e   = entry_t'(mem_rdata);

	always_comb begin
		top_lv = '0;
		any_ready = 1'b0;
		any_above_cur = 1'b0;
		for (int lv = 0; lv < LEVELS; lv++) begin
			if (count_q[lv] != '0) begin
				top_lv = LW'(lv);
				any_ready = 1'b1;
				if (LW'(lv) > cur_lv) any_above_cur = 1'b1;
			end
		end
	end

	// one ring pointer serves every memory access of the sequencer
	always_comb begin
		ptr_lv = lvl_q;
		ptr_off = '0;
		mem_we = 1'b0;
		case (state_q)
			S_ENQ: begin
				ptr_lv = enq_lv;
				ptr_off = count_q[enq_lv];
				mem_we = count_q[enq_lv] < CW'(QUEUE_DEPTH);
			end
			S_DQ:  ptr_lv = top_lv;
			S_RM:  ptr_off = i_q;
			S_SH:  ptr_off = j_q + CW'(1);
			S_SHW: begin
				ptr_off = j_q;
				mem_we = 1'b1;
			end
			default: ptr_lv = lvl_q;
		endcase
		ptr_addr = AW'(ptr_lv) * AW'(QUEUE_DEPTH) + AW'(wrap(head_q[ptr_lv], ptr_off));
	end

	mpts_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(ptr_addr),
		.wdata((state_q == S_SHW) ? mem_rdata : EW'(enq_q)),
		.raddr(ptr_addr),
		.rdata(mem_rdata)
	);

	always_comb begin
		if (base_priority == 4'd0) in_prio = PW'(1);
		else if (PW'(base_priority) > PW'(LEVELS)) in_prio = PW'(LEVELS);
		else in_prio = PW'(base_priority);
		in_e.id = task_id;
		in_e.prio = in_prio;
		in_e.flag = ai_flag;
		in_e.quantum = task_quantum;
		idle_ext = {24'b0, cfg_data};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_q <= mpts_pkg::BOOST_RESET;
			idle_id_q <= TASK_ID_WIDTH'(mpts_pkg::IDLE_ID_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				mpts_pkg::REG_AI_BOOST: boost_q <= cfg_data[mpts_pkg::BOOST_W-1:0];
				mpts_pkg::REG_IDLE_ID:  idle_id_q <= idle_ext[TASK_ID_WIDTH-1:0];
				default:                boost_q <= boost_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= '0;
			t_q <= '0;
			enq_q <= '0;
			cur_e_q <= '0;
			cur_task_q <= '0;
			cur_valid_q <= 1'b0;
			cur_idle_q <= 1'b0;
			qused_q <= '0;
			sw_total_q <= '0;
			boost_total_q <= '0;
			idle_total_q <= '0;
			ticks_q <= '0;
			sw_q <= 1'b0;
			drop_q <= 1'b0;
			pend_q <= 1'b0;
			old_q <= 1'b0;
			got_q <= 1'b0;
			found_q <= 1'b0;
			lvl_q <= '0;
			i_q <= '0;
			j_q <= '0;
			ready_q <= '0;
			for (int lv = 0; lv < LEVELS; lv++) begin
				head_q[lv] <= '0;
				count_q[lv] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						t_q <= in_e;
						sw_q <= 1'b0;
						drop_q <= 1'b0;
						pend_q <= 1'b0;
						old_q <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FIN;
					case (kind_q)
						mpts_pkg::KIND_TICK: begin
							ticks_q <= ticks_q + 32'd1;
							old_q <= 1'b1;
							if (!cur_valid_q || (cur_idle_q && any_ready) || (!cur_idle_q &&
									(qused_q >= cur_e_q.quantum || any_above_cur))) begin
								state_q <= S_DQ;
							end
						end
						mpts_pkg::KIND_ADD: begin
							enq_q <= t_q;
							pend_q <= !cur_valid_q;
							state_q <= S_ENQ;
						end
						mpts_pkg::KIND_WAKE: begin
							enq_q <= t_q;
							old_q <= 1'b1;
							pend_q <= cur_valid_q && (cur_idle_q || t_lv > cur_lv);
							state_q <= S_ENQ;
						end
						mpts_pkg::KIND_YIELD: begin
							if (cur_valid_q) begin
								enq_q <= cur_e_q;
								pend_q <= 1'b1;
								state_q <= cur_idle_q ? S_DQ : S_ENQ;
							end
						end
						mpts_pkg::KIND_SLEEP: begin
							if (cur_valid_q && !cur_idle_q) begin
								cur_valid_q <= 1'b0;
								state_q <= S_DQ;
							end
						end
						mpts_pkg::KIND_REMOVE: begin
							lvl_q <= t_lv;
							i_q <= '0;
							found_q <= 1'b0;
							state_q <= S_RM;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_ENQ: begin
					if (mem_we) begin
						count_q[enq_lv] <= count_q[enq_lv] + CW'(1);
						ready_q <= ready_q + RCW'(1);
					end else begin
						drop_q <= 1'b1;
					end
					pend_q <= 1'b0;
					state_q <= pend_q ? S_DQ : S_FIN;
				end
				S_DQ: begin
					got_q <= any_ready;
					if (any_ready) begin
						head_q[top_lv] <= wrap(head_q[top_lv], CW'(1));
						count_q[top_lv] <= count_q[top_lv] - CW'(1);
						ready_q <= ready_q - RCW'(1);
					end
					state_q <= S_SW;
				end
				S_SW: begin
					state_q <= S_FIN;
					if (!(cur_valid_q && (got_q ? (!cur_idle_q && cur_task_q == rd_e.id)
							: cur_idle_q))) begin
						sw_q <= 1'b1;
						sw_total_q <= sw_total_q + 32'd1;
						if (got_q && rd_e.flag) boost_total_q <= boost_total_q + 32'd1;
						// preempted real task goes back to its ring
						if (old_q && cur_valid_q && !cur_idle_q) begin
							enq_q <= cur_e_q;
							state_q <= S_ENQ;
						end
					end
					cur_valid_q <= 1'b1;
					cur_idle_q <= !got_q;
					cur_task_q <= got_q ? rd_e.id : idle_id_q;
					cur_e_q <= got_q ? rd_e : '0;
					qused_q <= '0;
				end
				S_RM: begin
					state_q <= (i_q == count_q[lvl_q]) ? S_RMEND : S_RMC;
				end
				S_RMC: begin
					if (rd_e.id == t_q.id) begin
						found_q <= 1'b1;
						j_q <= i_q;
						state_q <= S_SH;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_RM;
					end
				end
				S_SH: begin
					if (j_q + CW'(1) < count_q[lvl_q]) begin
						state_q <= S_SHW;
					end else begin
						count_q[lvl_q] <= count_q[lvl_q] - CW'(1);
						ready_q <= ready_q - RCW'(1);
						state_q <= S_RMEND;
					end
				end
				S_SHW: begin
					j_q <= j_q + CW'(1);
					state_q <= S_SH;
				end
				S_RMEND: begin
					if (cur_valid_q && !cur_idle_q && cur_task_q == t_q.id) begin
						cur_valid_q <= 1'b0;
						state_q <= S_DQ;
					end else begin
						drop_q <= !found_q;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (kind_q == mpts_pkg::KIND_TICK) begin
						if (cur_valid_q && !cur_idle_q) begin
							if (qused_q != '1) qused_q <= qused_q + QW'(1);
						end else begin
							idle_total_q <= idle_total_q + 32'd1;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready        = 1'b1;
	assign busy             = state_q != S_IDLE;
	assign result_valid     = state_q == S_OUT;
	assign running_task     = cur_valid_q ? cur_task_q : '0;
	assign running_idle     = cur_valid_q && cur_idle_q;
	assign switched         = sw_q;
	assign dropped          = drop_q;
	assign ready_count      = ready_q[7:0];
	assign switch_count     = sw_total_q;
	assign boosted_switches = boost_total_q;
	assign idle_ticks       = idle_total_q;
	assign tick_count       = ticks_q;

`ifndef ASSERT_OFF
	a_ready_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q <= RCW'(DEPTH))
		else $error("ready count beyond ring capacity");

	a_strobe_once: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid && !busy)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_fell_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(result_valid))
		else $error("busy dropped without a result");

	a_switch_runs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && switched |-> cur_valid_q)
		else $error("switch left nothing running");
`endif

endmodule

// ===== verif/tb_multilevel_priority_task_scheduler_core.sv =====
`timescale 1ns / 1ps
// tb_multilevel_priority_task_scheduler_core: self-checking bench for the scheduler core
// depends on mpts_pkg and multilevel_priority_task_scheduler_core; directed table, then random

module tb_multilevel_priority_task_scheduler_core;

	localparam int NLEV  = 10;
	localparam int DEPTH = 16;

	typedef struct packed {
		logic [7:0]  id;
		logic [3:0]  prio;
		logic        flag;
		logic [15:0] quantum;
	} task_rec_t;

	typedef struct packed {
		logic [7:0]  rt;
		logic        idle;
		logic        sw;
		logic        drop;
		logic [7:0]  rc;
		logic [31:0] tot;
		logic [31:0] boo;
		logic [31:0] idl;
		logic [31:0] tk;
	} sched_out_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  id;
		logic [3:0]  prio;
		logic        flag;
		logic [15:0] quantum;
		logic        chk;
		logic [7:0]  rt;
		logic        idle;
		logic        sw;
		logic        drop;
		logic [7:0]  rc;
	} stim_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        start = 0;
	logic        busy;
	logic [2:0]  kind = '0;
	logic [7:0]  task_id = '0;
	logic [3:0]  base_priority = '0;
	logic        ai_flag = 0;
	logic [15:0] task_quantum = '0;
	logic        result_valid;
	logic [7:0]  running_task;
	logic        running_idle;
	logic        switched;
	logic        dropped;
	logic [7:0]  ready_count;
	logic [31:0] switch_count;
	logic [31:0] boosted_switches;
	logic [31:0] idle_ticks;
	logic [31:0] tick_count;

	multilevel_priority_task_scheduler_core uut (.*);

	always #1 clk = ~clk;

	// scheduler model state
	task_rec_t   ring_mem [NLEV][DEPTH];
	int          ring_head [NLEV];
	int          ring_cnt [NLEV];
	logic [3:0]  boost_cfg;
	logic [7:0]  idle_cfg;
	logic [7:0]  run_id;
	bit          run_valid;
	bit          run_idle;
	task_rec_t   run_rec;
	logic [15:0] quantum_used;
	logic [31:0] switch_tot, boost_tot, idle_tot, tick_tot;

	sched_out_t  expected_q [$];
	stim_row_t   dir_rows [$];
	int          mismatches = 0;
	int          stall_cycles = 0;

	function automatic int eff_lvl(task_rec_t e);
		int p;
		p = e.prio;
		if (e.flag) p = p + boost_cfg;
		if (p > NLEV) p = NLEV;
		return p;
	endfunction

	function automatic bit ring_push(task_rec_t e);
		int lv;
		lv = eff_lvl(e) - 1;
		if (ring_cnt[lv] >= DEPTH) return 0;
		ring_mem[lv][(ring_head[lv] + ring_cnt[lv]) % DEPTH] = e;
		ring_cnt[lv]++;
		return 1;
	endfunction

	function automatic bit any_above(int level);
		for (int lv = level; lv < NLEV; lv++)
			if (ring_cnt[lv] != 0) return 1;
		return 0;
	endfunction

	function automatic void pick_next(bit old_running, inout bit sw, inout bit drop);
		task_rec_t e;
		bit got, same;
		got = 0;
		e = '0;
		for (int lv = NLEV - 1; lv >= 0 && !got; lv--) begin
			if (ring_cnt[lv] != 0) begin
				e = ring_mem[lv][ring_head[lv]];
				ring_head[lv] = (ring_head[lv] + 1) % DEPTH;
				ring_cnt[lv]--;
				got = 1;
			end
		end
		same = run_valid && (got ? (!run_idle && run_id == e.id) : run_idle);
		if (!same) begin
			if (old_running && run_valid && !run_idle)
				if (!ring_push(run_rec)) drop = 1;
			switch_tot++;
			if (got && e.flag) boost_tot++;
			sw = 1;
		end
		run_valid = 1;
		run_idle = !got;
		run_id = got ? e.id : idle_cfg;
		run_rec = e;
		quantum_used = 0;
	endfunction

	function automatic bit ring_remove(task_rec_t e);
		int lv, n;
		lv = eff_lvl(e) - 1;
		n = ring_cnt[lv];
		for (int i = 0; i < n; i++) begin
			if (ring_mem[lv][(ring_head[lv] + i) % DEPTH].id == e.id) begin
				for (int j = i; j + 1 < n; j++)
					ring_mem[lv][(ring_head[lv] + j) % DEPTH] =
						ring_mem[lv][(ring_head[lv] + j + 1) % DEPTH];
				ring_cnt[lv]--;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic sched_out_t sched_predict(stim_row_t s);
		task_rec_t t;
		sched_out_t o;
		bit sw, drop, due, found, is_cur;
		int ready;
		sw = 0;
		drop = 0;
		ready = 0;
		t.id = s.id;
		t.prio = (s.prio < 1) ? 4'd1 : (s.prio > NLEV) ? 4'(NLEV) : s.prio;
		t.flag = s.flag;
		t.quantum = s.quantum;
		case (s.kind)
			mpts_pkg::KIND_TICK: begin
				tick_tot++;
				if (!run_valid) due = 1;
				else if (run_idle) due = any_above(0);
				else due = quantum_used >= run_rec.quantum || any_above(eff_lvl(run_rec));
				if (due) pick_next(1, sw, drop);
				if (run_valid && !run_idle) begin
					if (quantum_used != 16'hFFFF) quantum_used++;
				end else begin
					idle_tot++;
				end
			end
			mpts_pkg::KIND_ADD: begin
				if (!ring_push(t)) drop = 1;
				if (!run_valid) pick_next(0, sw, drop);
			end
			mpts_pkg::KIND_WAKE: begin
				if (!ring_push(t)) drop = 1;
				if (run_valid && (run_idle || eff_lvl(t) > eff_lvl(run_rec)))
					pick_next(1, sw, drop);
			end
			mpts_pkg::KIND_YIELD: begin
				if (run_valid) begin
					if (!run_idle && !ring_push(run_rec)) drop = 1;
					pick_next(0, sw, drop);
				end
			end
			mpts_pkg::KIND_SLEEP: begin
				if (run_valid && !run_idle) begin
					run_valid = 0;
					pick_next(0, sw, drop);
				end
			end
			mpts_pkg::KIND_REMOVE: begin
				found = ring_remove(t);
				is_cur = run_valid && !run_idle && run_id == t.id;
				if (is_cur) begin
					run_valid = 0;
					pick_next(0, sw, drop);
				end
				if (!found && !is_cur) drop = 1;
			end
			default: ;
		endcase
		for (int lv = 0; lv < NLEV; lv++) ready += ring_cnt[lv];
		o.rt = run_valid ? run_id : 8'd0;
		o.idle = run_valid && run_idle;
		o.sw = sw;
		o.drop = drop;
		o.rc = ready[7:0];
		o.tot = switch_tot;
		o.boo = boost_tot;
		o.idl = idle_tot;
		o.tk = tick_tot;
		return o;
	endfunction

	function automatic void add_row(logic [2:0] k, logic [7:0] id, logic [3:0] p, logic f,
		logic [15:0] q, logic c = 0, logic [7:0] rt = 0, logic idl = 0, logic sw = 0,
		logic drp = 0, logic [7:0] rc = 0);
		dir_rows.push_back('{k, id, p, f, q, c, rt, idl, sw, drp, rc});
	endfunction

	// one word at a time: hold start until the block takes it
	task automatic send_item(stim_row_t s, int gap);
		sched_out_t o;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		kind <= s.kind;
		task_id <= s.id;
		base_priority <= s.prio;
		ai_flag <= s.flag;
		task_quantum <= s.quantum;
		do @(posedge clk); while (busy);
		o = sched_predict(s);
		if (s.chk) begin
			o.rt = s.rt;
			o.idle = s.idle;
			o.sw = s.sw;
			o.drop = s.drop;
			o.rc = s.rc;
		end
		expected_q.push_back(o);
	endtask

	task automatic cfg_write(logic [0:0] idx, logic [7:0] data);
		// start drops first so the last word is not taken again once busy falls
		start <= 0;
		while (expected_q.size() != 0 || busy) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == mpts_pkg::REG_AI_BOOST) boost_cfg = data[3:0];
		else idle_cfg = data;
		cfg_valid <= 0;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word, running_task %0d",
					running_task);
			end else begin
				sched_out_t e;
				sched_out_t a;
				e = expected_q.pop_front();
				a = '{running_task, running_idle, switched, dropped, ready_count,
					switch_count, boosted_switches, idle_ticks, tick_count};
				if (a !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: exp rt %0d idle %0b sw %0b drop %0b rc %0d",
							" tot %0d boo %0d idl %0d tk %0d | got rt %0d idle %0b sw %0b",
							" drop %0b rc %0d tot %0d boo %0d idl %0d tk %0d"},
							e.rt, e.idle, e.sw, e.drop, e.rc, e.tot, e.boo, e.idl, e.tk,
							a.rt, a.idle, a.sw, a.drop, a.rc, a.tot, a.boo, a.idl, a.tk);
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= 4000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		stim_row_t s;
		int r, lv, pos, phase_len;
		logic [3:0] boost_set [6];
		logic [7:0] idle_set [6];
		boost_set = '{4'd0, 4'd9, 4'd6, 4'd2, 4'd3, 4'd1};
		idle_set = '{8'd0, 8'd255, 8'd1, 8'd170, 8'd85, 8'd7};
		for (int i = 0; i < NLEV; i++) begin
			ring_head[i] = 0;
			ring_cnt[i] = 0;
		end
		boost_cfg = mpts_pkg::BOOST_RESET;
		idle_cfg = mpts_pkg::IDLE_ID_RESET;
		run_id = 0;
		run_valid = 0;
		run_idle = 0;
		run_rec = '0;
		quantum_used = 0;
		switch_tot = 0;
		boost_tot = 0;
		idle_tot = 0;
		tick_tot = 0;

		// first tick after reset brings up the idle task
		add_row(mpts_pkg::KIND_TICK, 8'd0, 4'd0, 0, 16'd1, 1, 8'd1, 1, 1, 0, 8'd0);
		add_row(mpts_pkg::KIND_REMOVE, 8'd9, 4'd3, 0, 16'd1, 1, 8'd1, 1, 0, 1, 8'd0);
		add_row(mpts_pkg::KIND_ADD, 8'd255, 4'd0, 0, 16'd1, 1, 8'd1, 1, 0, 0, 8'd1);
		add_row(mpts_pkg::KIND_ADD, 8'd0, 4'd15, 1, 16'hFFFF);
		add_row(mpts_pkg::KIND_ADD, 8'd7, 4'd10, 1, 16'd3);
		add_row(mpts_pkg::KIND_TICK, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_WAKE, 8'd20, 4'd9, 1, 16'd2);
		add_row(mpts_pkg::KIND_WAKE, 8'd30, 4'd1, 0, 16'd1);
		add_row(mpts_pkg::KIND_TICK, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_TICK, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_YIELD, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_SLEEP, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_REMOVE, 8'd255, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_REMOVE, 8'd7, 4'd10, 1, 16'd3);
		add_row(mpts_pkg::KIND_TICK, 8'd0, 4'd0, 0, 16'd1);
		add_row(3'd6, 8'hFF, 4'hF, 1, 16'hFFFF);
		add_row(3'd7, 8'hAA, 4'h5, 0, 16'h5555);
		add_row(mpts_pkg::KIND_ADD, 8'd1, 4'd5, 0, 16'd1);
		add_row(mpts_pkg::KIND_TICK, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_SLEEP, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_SLEEP, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_YIELD, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_TICK, 8'd0, 4'd0, 0, 16'd1);
		add_row(mpts_pkg::KIND_TICK, 8'd0, 4'd0, 0, 16'd1);

		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i], $urandom_range(0, 19));

		for (int ph = 0; ph < 6; ph++) begin
			cfg_write(mpts_pkg::REG_AI_BOOST, {4'd0, boost_set[ph]});
			cfg_write(mpts_pkg::REG_IDLE_ID, idle_set[ph]);
			phase_len = 170 + $urandom_range(0, 10);
			for (int n = 0; n < phase_len; n++) begin
				s = '0;
				r = $urandom_range(0, 99);
				// small id and priority pools so rings fill and removes hit
				s.id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
				s.prio = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(8, 10));
				s.flag = $urandom_range(0, 1);
				s.quantum = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
					: 16'($urandom_range(1, 4));
				if (r < 30) s.kind = mpts_pkg::KIND_TICK;
				else if (r < 55) s.kind = mpts_pkg::KIND_ADD;
				else if (r < 65) s.kind = mpts_pkg::KIND_WAKE;
				else if (r < 74) s.kind = mpts_pkg::KIND_YIELD;
				else if (r < 81) s.kind = mpts_pkg::KIND_SLEEP;
				else if (r < 96) begin
					s.kind = mpts_pkg::KIND_REMOVE;
					lv = $urandom_range(0, NLEV - 1);
					if (ring_cnt[lv] != 0 && $urandom_range(0, 3) != 0) begin
						pos = (ring_head[lv] + $urandom_range(0, ring_cnt[lv] - 1)) % DEPTH;
						s.id = ring_mem[lv][pos].id;
						s.prio = ring_mem[lv][pos].prio;
						s.flag = ring_mem[lv][pos].flag;
					end else if (run_valid && !run_idle && $urandom_range(0, 1)) begin
						s.id = run_id;
					end
				end else begin
					s.kind = 3'($urandom_range(6, 7));
				end
				send_item(s, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
			end
		end
		start <= 0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
